@@ rtl/wsbe_pkg.sv @@
// ----------------------------------------------------------------------------
// wsbe_pkg
// Shared widths, line patterns, register codes and the burst type of the
// WS2812 bit encoder with power limit.
// ----------------------------------------------------------------------------
package wsbe_pkg;

	localparam int ColorW = 8;
	localparam int LineW  = 8;
	localparam int TotalW = 16;
	localparam int CountW = 6;
	localparam int RunW   = 7;
	localparam int PosW   = 6;
	localparam int DataW  = 32;
	localparam int AddrW  = 3;

	localparam logic [LineW-1:0] IdlePat0 = 8'h92;
	localparam logic [LineW-1:0] IdlePat1 = 8'h49;
	localparam logic [LineW-1:0] IdlePat2 = 8'h24;

	localparam logic [TotalW-1:0] LimitReset = 16'd6375;
	localparam logic [CountW-1:0] CountReset = 6'd40;
	localparam logic [CountW-1:0] CountMin   = 6'd1;
	localparam logic [CountW-1:0] CountMax   = 6'd60;

	localparam logic RegLimit = 1'b0;
	localparam logic RegCount = 1'b1;

	typedef struct packed {
		logic             start;
		logic [LineW-1:0] b0;
		logic [LineW-1:0] b1;
		logic [LineW-1:0] b2;
		logic [RunW-1:0]  n;
	} burst_t;

endpackage

@@ rtl/wsbe_stream_if.sv @@
// ----------------------------------------------------------------------------
// wsbe_pixel_if / wsbe_line_if
// Valid-ready channels for colour bytes in and line bytes out.
// ----------------------------------------------------------------------------
interface wsbe_pixel_if import wsbe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ColorW-1:0] color_byte;
	logic              frame_last;

	modport source (output valid, output color_byte, output frame_last, input ready);
	modport sink (input valid, input color_byte, input frame_last, output ready);
endinterface

interface wsbe_line_if import wsbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LineW-1:0] line_byte;
	logic             run_end;

	modport source (output valid, output line_byte, output run_end, input ready);
	modport sink (input valid, input line_byte, input run_end, output ready);
endinterface

@@ rtl/wsbe_emitter.sv @@
// ----------------------------------------------------------------------------
// wsbe_emitter
// Plays out one encoded burst as line bytes, one per cycle while line.ready is
// high: optional start byte, three encoded bytes, zero latch bytes to its end.
// ----------------------------------------------------------------------------
module wsbe_emitter import wsbe_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  burst_t          burst,
	input  logic            burst_valid,
	output logic            burst_take,
	wsbe_line_if.source     line
);

	logic            valid_q;
	burst_t          cur_q;
	logic [PosW-1:0] pos_q;
	logic            at_end;
	logic [PosW-1:0] enc_pos;

	assign at_end     = ({1'b0, pos_q} == (cur_q.n - RunW'(1)));
	assign burst_take = burst_valid && (!valid_q || (line.ready && at_end));
	assign enc_pos    = pos_q - PosW'(cur_q.start);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else if (burst_take) begin
			valid_q <= 1'b1;
			pos_q   <= '0;
		end else if (valid_q && line.ready) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end
			pos_q <= pos_q + PosW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (burst_take) begin
			cur_q <= burst;
		end
	end

	always_comb begin
		line.line_byte = '0;
		if (!(cur_q.start && (pos_q == '0))) begin
			case (enc_pos)
				PosW'(0): line.line_byte = cur_q.b0;
				PosW'(1): line.line_byte = cur_q.b1;
				PosW'(2): line.line_byte = cur_q.b2;
				default:  line.line_byte = '0;
			endcase
		end
	end

	assign line.valid   = valid_q;
	assign line.run_end = at_end;

endmodule

@@ rtl/ws2812_bit_encoder_power_limit.sv @@
// ----------------------------------------------------------------------------
// ws2812_bit_encoder_power_limit
// WS2812 three-bit line encoder with a per-frame power limit.
// ----------------------------------------------------------------------------
// Colour bytes of a frame enter on the pixel channel, the last one marked by
// frame_last. Each is encoded in the cycle it is accepted and held in one
// register stage, from which the emitter plays out line bytes on the line
// channel, one per cycle while line.ready is high: a zero start byte on the
// first byte of a frame, three encoded bytes, and after the last byte of the
// frame the configured number of zero latch bytes, clamped to 1..60. run_end
// marks the final line byte of an item. The burst passes the register stage
// and the emitter's burst register before its first line byte. The block
// takes a new colour byte while the previous one is still being played out,
// so the rate is set by the line channel: three line bytes per colour byte
// in a frame, plus a start byte and the latch bytes. On a line stall the
// current byte holds and one more item can be taken before pixel.ready drops.
// Reset clears frame state, running total and both channels and loads the
// defaults (limit 6375, 40 latch bytes). APB registers: 0x0 limit, 0x4 count.
// ----------------------------------------------------------------------------
module ws2812_bit_encoder_power_limit import wsbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	wsbe_pixel_if.sink        pixel,
	wsbe_line_if.source       line,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	logic [TotalW-1:0] limit_q;
	logic [CountW-1:0] count_q;
	logic [TotalW-1:0] sent_total_q;
	logic              frame_open_q;

	logic              s1_valid_q;
	burst_t            burst_s1;
	burst_t            burst_d;
	logic              burst_take;
	logic              in_fire;
	logic              cfg_wr;

	logic              start;
	logic [ColorW-1:0] c_eff;
	logic [TotalW:0]   sum;
	logic [TotalW-1:0] base;
	logic [CountW-1:0] cnt;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LimitReset;
			count_q <= CountReset;
		end else if (cfg_wr) begin
			case (paddr[2])
				RegLimit: limit_q <= pwdata[TotalW-1:0];
				RegCount: count_q <= pwdata[CountW-1:0];
				default:  limit_q <= limit_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			RegLimit: prdata = DataW'(limit_q);
			RegCount: prdata = DataW'(count_q);
			default:  prdata = '0;
		endcase
	end

	assign in_fire     = pixel.valid && pixel.ready;
	assign pixel.ready = !s1_valid_q || burst_take;

	always_comb begin
		start = !frame_open_q;
		base  = start ? '0 : sent_total_q;
		c_eff = (!start && (sent_total_q >= limit_q)) ? '0 : pixel.color_byte;
		sum   = {1'b0, base} + (TotalW + 1)'(c_eff);
		if (count_q < CountMin) begin
			cnt = CountMin;
		end else if (count_q > CountMax) begin
			cnt = CountMax;
		end else begin
			cnt = count_q;
		end
		burst_d.start = start;
		burst_d.b0 = IdlePat0 | {1'b0, c_eff[7], 2'b0, c_eff[6], 2'b0, c_eff[5]};
		burst_d.b1 = IdlePat1 | {2'b0, c_eff[4], 2'b0, c_eff[3], 2'b0};
		burst_d.b2 = IdlePat2 | {c_eff[2], 2'b0, c_eff[1], 2'b0, c_eff[0], 1'b0};
		burst_d.n  = RunW'(3) + RunW'(start)
			+ (pixel.frame_last ? RunW'(cnt) : RunW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_total_q <= '0;
			frame_open_q <= 1'b0;
			s1_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				sent_total_q <= sum[TotalW] ? '1 : sum[TotalW-1:0];
				frame_open_q <= !pixel.frame_last;
				s1_valid_q   <= 1'b1;
			end else if (burst_take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			burst_s1 <= burst_d;
		end
	end

	wsbe_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst_s1),
		.burst_valid (s1_valid_q),
		.burst_take  (burst_take),
		.line        (line)
	);

`ifndef SYNTHESIS
	a_last_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && pixel.frame_last) |=> !frame_open_q)
		else $error("frame still open after its last byte");

	a_burst_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !burst_take) |=> (s1_valid_q && $stable(burst_s1)))
		else $error("pending burst lost before the emitter took it");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_open_q) |=> (sent_total_q >= $past(sent_total_q)))
		else $error("running total decreased inside a frame");
`endif

endmodule
